### rtl/swdik_pkg.sv
`default_nettype none

package swdik_pkg;

  // CORDIC depth, valid range 8..24
  localparam int ROTATION_STEPS = 16;
  localparam int NUM_LANES      = 4;
  localparam int STEP_W         = 5;

  // datapath widths: x/y in Q.24 metres/s, z in Q.24 radians
  localparam int XW = 36;
  localparam int ZW = 28;
  localparam int AW = 16;
  localparam int SW = 20;

  localparam logic signed [ZW-1:0] PI_Q24      = 28'sd52707179;
  localparam logic signed [AW:0]   ANGLE_LIMIT = 17'sd25736;
  localparam logic [29:0]          INV_GAIN    = 30'd652032874;
  localparam logic [SW-1:0]        SPIN_MAX    = 20'hFFFFF;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_X_OFFSET = 2'd0;
  localparam logic [1:0] REG_Y_OFFSET = 2'd1;
  localparam logic [1:0] REG_INV_RAD  = 2'd2;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  typedef lane_t [NUM_LANES-1:0] lanes_t;

  function automatic logic signed [ZW-1:0] atan_q24(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] r;
    r = '0;
    unique case (i)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/swdik_front.sv
`default_nettype none

module swdik_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  output logic                        ready_o,
  input  wire logic signed [15:0]     vel_x_i,
  input  wire logic signed [15:0]     vel_y_i,
  input  wire logic signed [15:0]     yaw_rate_i,
  input  wire logic [14:0]            x_off_i,
  input  wire logic [14:0]            y_off_i,
  output logic                        valid_o,
  input  wire logic                   ready_i,
  output swdik_pkg::lanes_t           lanes_o
);
  import swdik_pkg::*;

  logic                 va_q, vb_q;
  logic                 rdy_a, rdy_b;
  logic signed [15:0]   vx_q, vy_q;
  logic signed [31:0]   wx_q, wy_q;
  lanes_t               lanes_d, lanes_q;

  assign rdy_b   = !vb_q || ready_i;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;
  assign valid_o = vb_q;
  assign lanes_o = lanes_q;

  // stage A: yaw rate times offsets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (rdy_a) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      vx_q <= vel_x_i;
      vy_q <= vel_y_i;
      wx_q <= yaw_rate_i * $signed({1'b0, x_off_i});
      wy_q <= yaw_rate_i * $signed({1'b0, y_off_i});
    end
  end

  // stage B: module vectors, folded into the right half plane
  always_comb begin
    logic signed [XW-1:0] vx, vy, wx, wy;
    logic signed [XW-1:0] cx [NUM_LANES];
    logic signed [XW-1:0] cy [NUM_LANES];
    vx = $signed({{(XW-28){vx_q[15]}}, vx_q, 12'b0});
    vy = $signed({{(XW-28){vy_q[15]}}, vy_q, 12'b0});
    wx = $signed({{(XW-32){wx_q[31]}}, wx_q});
    wy = $signed({{(XW-32){wy_q[31]}}, wy_q});
    cx[0] = vx - wy;  cy[0] = vy + wx;   // front left
    cx[1] = vx + wy;  cy[1] = vy + wx;   // front right
    cx[2] = vx - wy;  cy[2] = vy - wx;   // rear left
    cx[3] = vx + wy;  cy[3] = vy - wx;   // rear right
    for (int k = 0; k < NUM_LANES; k++) begin
      lanes_d[k].zero = (cx[k] == '0) && (cy[k] == '0);
      if (cx[k][XW-1]) begin
        lanes_d[k].x = -cx[k];
        lanes_d[k].y = -cy[k];
        lanes_d[k].z = cy[k][XW-1] ? -PI_Q24 : PI_Q24;
      end else begin
        lanes_d[k].x = cx[k];
        lanes_d[k].y = cy[k];
        lanes_d[k].z = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (rdy_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      lanes_q <= lanes_d;
    end
  end

endmodule

`default_nettype wire

### rtl/swdik_cell.sv
`default_nettype none

module swdik_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [swdik_pkg::STEP_W-1:0] step_i,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire swdik_pkg::lanes_t           lanes_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output swdik_pkg::lanes_t                lanes_o
);
  import swdik_pkg::*;

  logic   valid_q;
  lanes_t lanes_d, lanes_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

  // one vectoring micro-rotation on all four lanes
  always_comb begin
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    at = atan_q24(step_i);
    for (int k = 0; k < NUM_LANES; k++) begin
      xs = lanes_i[k].x >>> step_i;
      ys = lanes_i[k].y >>> step_i;
      lanes_d[k].zero = lanes_i[k].zero;
      if (!lanes_i[k].y[XW-1]) begin
        lanes_d[k].x = lanes_i[k].x + ys;
        lanes_d[k].y = lanes_i[k].y - xs;
        lanes_d[k].z = lanes_i[k].z + at;
      end else begin
        lanes_d[k].x = lanes_i[k].x - ys;
        lanes_d[k].y = lanes_i[k].y + xs;
        lanes_d[k].z = lanes_i[k].z - at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      lanes_q <= lanes_d;
    end
  end

endmodule

`default_nettype wire

### rtl/swdik_back.sv
`default_nettype none

module swdik_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  output logic                                    ready_o,
  input  wire swdik_pkg::lanes_t                  lanes_i,
  input  wire logic [15:0]                        inv_rad_i,
  output logic                                    valid_o,
  input  wire logic                               ready_i,
  output logic [swdik_pkg::NUM_LANES-1:0][swdik_pkg::AW-1:0] angle_o,
  output logic [swdik_pkg::NUM_LANES-1:0][swdik_pkg::SW-1:0] spin_o
);
  import swdik_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  logic [NUM_LANES-1:0][47:0]   ph_q;
  logic [NUM_LANES-1:0][46:0]   pl_q;
  logic [NUM_LANES-1:0][AW-1:0] ang1_q, ang2_q, ang3_q, ang4_q;
  logic [NUM_LANES-1:0]         z1_q, z2_q, z3_q, z4_q;
  logic [NUM_LANES-1:0][33:0]   len_q;
  logic [NUM_LANES-1:0][49:0]   prod_q;
  logic [NUM_LANES-1:0][SW-1:0] spin_q;

  logic [NUM_LANES-1:0][47:0]   ph_d;
  logic [NUM_LANES-1:0][46:0]   pl_d;
  logic [NUM_LANES-1:0][AW-1:0] ang_d;
  logic [NUM_LANES-1:0][33:0]   len_d;
  logic [NUM_LANES-1:0][SW-1:0] spin_d;

  assign r4 = !v4_q || ready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign ready_o = r1;
  assign valid_o = v4_q;
  assign angle_o = ang4_q;
  assign spin_o  = spin_q;

  // stage 1: split gain product, round and clamp angle
  always_comb begin
    logic [XW-2:0]        xu;
    logic signed [ZW-1:0] zr;
    logic signed [AW:0]   a;
    for (int k = 0; k < NUM_LANES; k++) begin
      xu = lanes_i[k].x[XW-1] ? '0 : lanes_i[k].x[XW-2:0];
      ph_d[k] = 48'(xu[XW-2:17]) * 48'(INV_GAIN);
      pl_d[k] = 47'(xu[16:0]) * 47'(INV_GAIN);
      zr = lanes_i[k].z + ZW'(1024);
      a  = zr[ZW-1:11];
      if (a > ANGLE_LIMIT)       a = ANGLE_LIMIT;
      else if (a < -ANGLE_LIMIT) a = -ANGLE_LIMIT;
      ang_d[k] = lanes_i[k].zero ? '0 : a[AW-1:0];
    end
  end

  // stage 2: length = x / gain, rounded
  always_comb begin
    logic [65:0] sum;
    for (int k = 0; k < NUM_LANES; k++) begin
      sum = {1'b0, ph_q[k], 17'b0} + 66'(pl_q[k]) + (66'd1 << 29);
      len_d[k] = sum[63:30];
    end
  end

  // stage 4: round, saturate
  always_comb begin
    logic [50:0] s;
    for (int k = 0; k < NUM_LANES; k++) begin
      s = 51'(prod_q[k]) + (51'd1 << 23);
      if (z3_q[k])                 spin_d[k] = '0;
      else if (s[50:24] > 27'(SPIN_MAX)) spin_d[k] = SPIN_MAX;
      else                         spin_d[k] = s[24+SW-1:24];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      ph_q   <= ph_d;
      pl_q   <= pl_d;
      ang1_q <= ang_d;
      for (int k = 0; k < NUM_LANES; k++) z1_q[k] <= lanes_i[k].zero;
    end
    if (r2 && v1_q) begin
      len_q  <= len_d;
      ang2_q <= ang1_q;
      z2_q   <= z1_q;
    end
    if (r3 && v2_q) begin
      for (int k = 0; k < NUM_LANES; k++) prod_q[k] <= 50'(len_q[k]) * 50'(inv_rad_i);
      ang3_q <= ang2_q;
      z3_q   <= z2_q;
    end
    if (r4 && v3_q) begin
      spin_q <= spin_d;
      ang4_q <= ang3_q;
      z4_q   <= z3_q;
    end
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_chk
    a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      v4_q |-> ($signed(ang4_q[k]) <= ANGLE_LIMIT && $signed(ang4_q[k]) >= -ANGLE_LIMIT))
      else $error("angle outside clamp");
    a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (v4_q && z4_q[k]) |-> (ang4_q[k] == '0 && spin_q[k] == '0))
      else $error("zero vector gave nonzero result");
  end

  a_hold_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !r2) |=> v1_q)
    else $error("stage 1 word dropped under stall");

endmodule

`default_nettype wire

### rtl/swerve_drive_inverse_kinematics.sv
`default_nettype none
// Channel   | Dir | Handshake              | Content
// s_axis    | in  | tvalid/tready          | one velocity command word
// m_axis    | out | tvalid/tready          | angles and spins for four modules
// apb       | in  | psel/penable/pwrite    | offsets and inverse wheel radius
//
// Two front stages, one CORDIC cell per rotation step and four back stages
// (gain and radius multiplies, split to stay within 32-bit-class
// multipliers). Takes one word per cycle while m_axis is not stalled;
// every stage holds its own valid, so a stall on m_axis only backs up
// as far as the first empty stage.
// Reset empties the pipeline and loads the register defaults; no clearing pass.

module swerve_drive_inverse_kinematics (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // vel_x [15:0], vel_y [31:16], yaw_rate [47:32]
  input  wire logic [47:0]  s_axis_tdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // fl/fr/rl/rr_angle [63:0], then fl/fr/rl/rr_spin [143:64]
  output logic [143:0]      m_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import swdik_pkg::*;

  logic [14:0] x_off_q, y_off_q;
  logic [15:0] inv_rad_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q   <= 15'd4096;
      y_off_q   <= 15'd8192;
      inv_rad_q <= 16'd45956;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_X_OFFSET: x_off_q   <= pwdata[14:0];
        REG_Y_OFFSET: y_off_q   <= pwdata[14:0];
        REG_INV_RAD:  inv_rad_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_X_OFFSET: prdata = {17'b0, x_off_q};
      REG_Y_OFFSET: prdata = {17'b0, y_off_q};
      REG_INV_RAD:  prdata = {16'b0, inv_rad_q};
      default:      prdata = '0;
    endcase
  end

  // chain links: index 0 is the front output, ROTATION_STEPS the last cell
  lanes_t                      link_lanes [ROTATION_STEPS+1];
  logic [ROTATION_STEPS:0]     link_valid;
  logic [ROTATION_STEPS:0]     link_ready;

  swdik_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .vel_x_i    (s_axis_tdata[15:0]),
    .vel_y_i    (s_axis_tdata[31:16]),
    .yaw_rate_i (s_axis_tdata[47:32]),
    .x_off_i    (x_off_q),
    .y_off_i    (y_off_q),
    .valid_o    (link_valid[0]),
    .ready_i    (link_ready[0]),
    .lanes_o    (link_lanes[0])
  );

  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_cell
    swdik_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (STEP_W'(i)),
      .valid_i (link_valid[i]),
      .ready_o (link_ready[i]),
      .lanes_i (link_lanes[i]),
      .valid_o (link_valid[i+1]),
      .ready_i (link_ready[i+1]),
      .lanes_o (link_lanes[i+1])
    );
  end

  logic [NUM_LANES-1:0][AW-1:0] angle;
  logic [NUM_LANES-1:0][SW-1:0] spin;

  swdik_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (link_valid[ROTATION_STEPS]),
    .ready_o   (link_ready[ROTATION_STEPS]),
    .lanes_i   (link_lanes[ROTATION_STEPS]),
    .inv_rad_i (inv_rad_q),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .angle_o   (angle),
    .spin_o    (spin)
  );

  // lane 0 (front left) lands in the lowest bits
  assign m_axis_tdata = {spin, angle};

endmodule

`default_nettype wire
